@@ hdl/lmf_pkg.sv @@
// shared types and constants of the led matrix fade engine
`default_nettype none
package lmf_pkg;

  localparam int COORD_W   = 3;
  localparam int CHAN_W    = 8;
  localparam int PHASE_W   = 8;
  localparam int RATE_W    = 16;
  localparam int TICK_W    = 17;
  localparam int COLOR_W   = 24;
  localparam int WORD_W    = 3 * CHAN_W + PHASE_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int LANES     = 3;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_REFRESH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_RATE  = 1'b1;

  typedef struct packed {
    logic               accept_wr;
    logic               accept_rf;
    logic               clr_we;
    logic               rd_en;
    logic               calc;
    logic               div_step;
    logic               emit;
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic               pix_last;
  } lmf_cmd_t;

  typedef struct packed {
    logic out_free;
  } lmf_sts_t;

endpackage
`default_nettype wire

@@ hdl/lmf_in_if.sv @@
// input channel interface: pixel writes and refresh ticks
`default_nettype none
interface lmf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [lmf_pkg::COORD_W-1:0]   col;
  logic [lmf_pkg::COORD_W-1:0]   row;
  logic [lmf_pkg::CHAN_W-1:0]    red_in;
  logic [lmf_pkg::CHAN_W-1:0]    green_in;
  logic [lmf_pkg::CHAN_W-1:0]    blue_in;

  modport source (output valid, action, col, row, red_in, green_in, blue_in, input ready);
  modport sink (input valid, action, col, row, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

@@ hdl/lmf_out_if.sv @@
// result channel interface: emitted pixels
`default_nettype none
interface lmf_out_if;
  logic                          valid;
  logic                          ready;
  logic [lmf_pkg::COORD_W-1:0]   pix_x;
  logic [lmf_pkg::COORD_W-1:0]   pix_y;
  logic [lmf_pkg::COLOR_W-1:0]   color;
  logic                          drawn;
  logic                          last;

  modport source (output valid, pix_x, pix_y, color, drawn, last, input ready);
  modport sink (input valid, pix_x, pix_y, color, drawn, last, output ready);
endinterface
`default_nettype wire

@@ hdl/lmf_ram.sv @@
// generic single write port, single read port ram with registered read
`default_nettype none
module lmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/lmf_datapath.sv @@
// pixel store, tick counter, config registers, fade multiply and divide, output register
`default_nettype none
module lmf_datapath #(
  parameter int GRID_SIZE = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [lmf_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [lmf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic [lmf_pkg::COORD_W-1:0]         in_col,
  input  wire logic [lmf_pkg::COORD_W-1:0]         in_row,
  input  wire logic [lmf_pkg::CHAN_W-1:0]          in_red,
  input  wire logic [lmf_pkg::CHAN_W-1:0]          in_green,
  input  wire logic [lmf_pkg::CHAN_W-1:0]          in_blue,
  input  wire lmf_pkg::lmf_cmd_t                   cmd,
  input  wire logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] cell_addr,
  output      lmf_pkg::lmf_sts_t                   sts,
  input  wire logic                                out_ready,
  output      logic                                out_valid,
  output      logic [lmf_pkg::COORD_W-1:0]         out_pix_x,
  output      logic [lmf_pkg::COORD_W-1:0]         out_pix_y,
  output      logic [lmf_pkg::COLOR_W-1:0]         out_color,
  output      logic                                out_drawn,
  output      logic                                out_last
);

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = lmf_pkg::CHAN_W;
  localparam int PW    = lmf_pkg::PHASE_W;

  logic [PW-1:0]                  steps_r;
  logic [lmf_pkg::RATE_W-1:0]     rate_r;
  logic [lmf_pkg::TICK_W-1:0]     tick_r, tick_nxt;
  logic                           adv_r, adv_nxt;

  logic                           we;
  logic [AW-1:0]                  waddr;
  logic [lmf_pkg::WORD_W-1:0]     wdata;
  logic [lmf_pkg::WORD_W-1:0]     rdata;
  logic                           wr_in_grid;
  logic [AW-1:0]                  wr_addr;

  logic [PW-1:0]                  ph, ph_new, diff;
  logic                           ph_inc;
  logic                           drawn_r, drawn_nxt;
  logic                           zero_r, zero_nxt;

  logic [CW-1:0]                  rem_r [lmf_pkg::LANES];
  logic [CW-1:0]                  rem_nxt [lmf_pkg::LANES];
  logic [CW-1:0]                  num_r [lmf_pkg::LANES];
  logic [CW-1:0]                  num_nxt [lmf_pkg::LANES];
  logic [2*CW-1:0]                prod [lmf_pkg::LANES];
  logic [CW:0]                    sh [lmf_pkg::LANES];
  logic                           ge [lmf_pkg::LANES];

  logic                           out_valid_r, out_valid_nxt;
  logic [lmf_pkg::COORD_W-1:0]    pix_x_r, pix_y_r;
  logic [lmf_pkg::COLOR_W-1:0]    color_r;
  logic                           odrawn_r, olast_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
      rate_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lmf_pkg::REG_FADE_STEPS: steps_r <= cfg_data[PW-1:0];
        lmf_pkg::REG_FADE_RATE:  rate_r  <= cfg_data[lmf_pkg::RATE_W-1:0];
      endcase
    end
  end

  // refresh tick counter
  always_comb begin
    tick_nxt = tick_r;
    adv_nxt  = adv_r;
    if (cmd.accept_rf) begin
      tick_nxt = tick_r + 1'b1;
      adv_nxt  = {1'b0, rate_r} < tick_nxt;
      if (adv_nxt) begin
        tick_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      adv_r  <= 1'b0;
    end else begin
      tick_r <= tick_nxt;
      adv_r  <= adv_nxt;
    end
  end

  // pixel store write port
  assign wr_in_grid = (32'(in_col) < 32'(GRID_SIZE)) && (32'(in_row) < 32'(GRID_SIZE));
  assign wr_addr    = AW'(32'(in_col) * 32'(GRID_SIZE) + 32'(in_row));

  always_comb begin
    we    = 1'b0;
    waddr = cell_addr;
    wdata = '0;
    priority if (cmd.clr_we) begin
      we = 1'b1;
    end else if (cmd.accept_wr) begin
      we    = wr_in_grid;
      waddr = wr_addr;
      wdata = {in_red, in_green, in_blue, PW'(0)};
    end else if (cmd.calc) begin
      we    = 1'b1;
      wdata = {rdata[lmf_pkg::WORD_W-1:PW], ph_new};
    end else begin
      we = 1'b0;
    end
  end

  lmf_ram #(
    .WIDTH (lmf_pkg::WORD_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (cell_addr),
    .rdata (rdata)
  );

  // phase step and scale
  assign ph        = rdata[PW-1:0];
  assign ph_inc    = adv_r && (steps_r != '0) && (ph < steps_r);
  assign ph_new    = ph_inc ? PW'(ph + 1'b1) : ph;
  assign zero_nxt  = (steps_r == '0);
  assign drawn_nxt = (ph_new <= steps_r);
  assign diff      = zero_nxt ? PW'(1) : PW'(steps_r - ph_new);

  // restoring divide by fade steps, one quotient bit per step per lane
  always_comb begin
    for (int i = 0; i < lmf_pkg::LANES; i++) begin
      prod[i]    = (2*CW)'(rdata[lmf_pkg::WORD_W-1-CW*i -: CW]) * (2*CW)'(diff);
      sh[i]      = {rem_r[i], num_r[i][CW-1]};
      ge[i]      = sh[i] >= {1'b0, steps_r};
      rem_nxt[i] = rem_r[i];
      num_nxt[i] = num_r[i];
      if (cmd.calc) begin
        rem_nxt[i] = prod[i][2*CW-1:CW];
        num_nxt[i] = prod[i][CW-1:0];
      end else if (cmd.div_step && !zero_r) begin
        rem_nxt[i] = ge[i] ? CW'(sh[i] - {1'b0, steps_r}) : sh[i][CW-1:0];
        num_nxt[i] = {num_r[i][CW-2:0], ge[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < lmf_pkg::LANES; i++) begin
      rem_r[i] <= rem_nxt[i];
      num_r[i] <= num_nxt[i];
    end
    if (cmd.calc) begin
      drawn_r <= drawn_nxt;
      zero_r  <= zero_nxt;
    end
  end

  // output register
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pix_x_r  <= cmd.pix_x;
      pix_y_r  <= cmd.pix_y;
      olast_r  <= cmd.pix_last;
      odrawn_r <= drawn_r;
      color_r  <= drawn_r ? {num_r[0], num_r[1], num_r[2]} : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix_x = pix_x_r;
  assign out_pix_y = pix_y_r;
  assign out_color = color_r;
  assign out_drawn = odrawn_r;
  assign out_last  = olast_r;

endmodule
`default_nettype wire

@@ hdl/lmf_ctrl.sv @@
// controller state machine: store clear, transaction accept, per-pixel sequencing
`default_nettype none
module lmf_ctrl #(
  parameter int GRID_SIZE = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  input  wire logic                                   in_action,
  output      logic                                   in_ready,
  input  wire lmf_pkg::lmf_sts_t                      sts,
  output      lmf_pkg::lmf_cmd_t                      cmd,
  output      logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] cell_addr
);

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(GRID_SIZE);
  localparam int DW    = lmf_pkg::DIV_CNT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [DW-1:0] div_cnt_r, div_cnt_nxt;
  logic          cell_last;

  assign cell_last = (cnt_r == AW'(CELLS - 1));
  assign cell_addr = cnt_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    div_cnt_nxt = div_cnt_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.pix_x   = lmf_pkg::COORD_W'(x_r);
    cmd.pix_y   = lmf_pkg::COORD_W'(y_r);
    cmd.pix_last = cell_last;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (cell_last) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = AW'(cnt_r + 1'b1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == lmf_pkg::ACT_WRITE) begin
            cmd.accept_wr = 1'b1;
          end else begin
            cmd.accept_rf = 1'b1;
            cnt_nxt       = '0;
            x_nxt         = '0;
            y_nxt         = '0;
            state_nxt     = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc    = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = DW'(div_cnt_r + 1'b1);
        if (div_cnt_r == DW'(lmf_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (cell_last) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = AW'(cnt_r + 1'b1);
            state_nxt = S_READ;
            if (y_r == XW'(GRID_SIZE - 1)) begin
              y_nxt = '0;
              x_nxt = XW'(x_r + 1'b1);
            end else begin
              y_nxt = XW'(y_r + 1'b1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      cnt_r     <= '0;
      x_r       <= '0;
      y_r       <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.pix_last) |=> (state_r == S_IDLE))
    else $error("frame end did not return to idle");

  a_refresh_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept_rf |=> (cnt_r == '0 && x_r == '0 && y_r == '0 && state_r == S_READ))
    else $error("refresh did not start at first pixel");

  a_calc_then_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC) |=> (state_r == S_DIV && div_cnt_r == '0))
    else $error("divide did not start after calc");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept_wr || cmd.accept_rf) |-> ($past(state_r) != S_CLEAR || state_r == S_IDLE))
    else $error("transaction accepted outside idle");

endmodule
`default_nettype wire

@@ hdl/led_matrix_fade_engine_unit.sv @@
// top level of the led matrix fade engine
// A pixel write transaction is taken in idle, and the controller stays idle. A
// refresh transaction is accepted in idle and then walks each pixel through
// store read, phase update and multiply, an eight-step restoring divide by
// fade_steps and an output load, which waits while the output side stalls.
// Pixels leave in x-major order through a one-entry output register. After
// reset the pixel store is cleared one entry per cycle while no transaction
// is accepted; config writes are taken at any time.
`default_nettype none
module led_matrix_fade_engine_unit #(
  parameter int GRID_SIZE = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  lmf_in_if.sink                              in_chan,
  lmf_out_if.source                           out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [lmf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [lmf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);

  lmf_pkg::lmf_cmd_t cmd;
  lmf_pkg::lmf_sts_t sts;
  logic [AW-1:0]     cell_addr;

  lmf_ctrl #(
    .GRID_SIZE (GRID_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .sts       (sts),
    .cmd       (cmd),
    .cell_addr (cell_addr)
  );

  lmf_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_col    (in_chan.col),
    .in_row    (in_chan.row),
    .in_red    (in_chan.red_in),
    .in_green  (in_chan.green_in),
    .in_blue   (in_chan.blue_in),
    .cmd       (cmd),
    .cell_addr (cell_addr),
    .sts       (sts),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_pix_x (out_chan.pix_x),
    .out_pix_y (out_chan.pix_y),
    .out_color (out_chan.color),
    .out_drawn (out_chan.drawn),
    .out_last  (out_chan.last)
  );

endmodule
`default_nettype wire
